// File: rtl/core/tile_color_count_detector_macros.svh
// ----------------------------------------------------------------------------
// Tile colour count detector - assertion macros
// Short forms for the concurrent checks on the detector ports, clocked on
// i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TILE_COLOR_COUNT_DETECTOR_MACROS_SVH
`define TILE_COLOR_COUNT_DETECTOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TCCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tccd_pkg.sv
// ----------------------------------------------------------------------------
// Tile colour count detector - package
// Item types, register indexes, reset values and field widths shared by the
// detector and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_COLOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    // register widths
    localparam int TS_W    = 7;
    localparam int CNT_W   = 13;
    localparam int COLOR_W = 32;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;

    // output field widths
    localparam int TILE_COL_W = 10;
    localparam int ROW_W      = 12;

    // reset values
    localparam logic [TS_W-1:0]    RST_TILE_SIZE    = 7'd16;
    localparam logic [CNT_W-1:0]   RST_THRESHOLD    = 13'd50;
    localparam logic [COLOR_W-1:0] RST_MATCH_COLOR  = 32'hFFFF_0000;
    localparam logic [FW_W-1:0]    RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]    RST_FRAME_HEIGHT = 13'd480;

    // limits
    localparam logic [FH_W-1:0]  HEIGHT_LIMIT = 13'd4096;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 13'h1FFF;

    // parameter defaults
    localparam int DEF_MAX_FRAME_WIDTH = 1024;
    localparam int DEF_MAX_TILE_SIZE   = 64;

    // one pixel item
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_argb;
        logic               frame_start;
    } t_pixel_in;

    // one tile result item
    typedef struct packed {
        logic [TILE_COL_W-1:0] tile_column;
        logic [ROW_W-1:0]      tile_row;
        logic [CNT_W-1:0]      match_count;
        logic                  detected;
    } t_tile_out;

endpackage

// File: rtl/core/tile_color_count_detector.sv
// ----------------------------------------------------------------------------
// Tile colour count detector
// Counts pixels equal to a match colour in each square tile of a raster
// frame and reports every complete tile with its count and a threshold flag.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in steady state. A pixel is counted in a two-stage
// read-modify-write loop around a line store of MAX_FRAME_WIDTH tile-column
// counts (read in the accept cycle, updated and written back from the update
// stage, with the previous write forwarded); a tile result leaves the update
// stage through an output register. After reset the line store is cleared
// one entry a cycle, and input is held off until all MAX_FRAME_WIDTH entries
// (1024 by default) are clear; configuration writes are taken during that
// time. A write to tile_size holds input off while a bit-serial divider
// re-derives the tile coordinates of the current position over
// max(clog2(MAX_FRAME_WIDTH), 12) quotient bits. Input is also held while a
// finished tile result waits for a stalled, full output register.
`timescale 1ns / 1ps

module tile_color_count_detector #(
    parameter int MAX_FRAME_WIDTH = tccd_pkg::DEF_MAX_FRAME_WIDTH,
    parameter int MAX_TILE_SIZE   = tccd_pkg::DEF_MAX_TILE_SIZE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tccd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tccd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tccd_pkg::t_pixel_in              i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tccd_pkg::t_tile_out              o_out
);

    import tccd_pkg::*;

    localparam int XW  = $clog2(MAX_FRAME_WIDTH);
    localparam int FWW = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int FCW = (FWW > FW_W) ? FWW : FW_W;
    localparam int TW  = $clog2(MAX_TILE_SIZE + 1);
    localparam int TCW = (TW > TS_W) ? TW : TS_W;
    localparam int OW  = $clog2(MAX_TILE_SIZE);
    localparam int YW  = ROW_W;
    localparam int DW  = (XW > YW) ? XW : YW;
    localparam int DCW = $clog2(DW + 1);

    // controller states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // configuration registers
    logic [TS_W-1:0]    r_tile_size;
    logic [CNT_W-1:0]   r_threshold;
    logic [COLOR_W-1:0] r_match_color;
    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;

    // control
    logic [1:0]     r_state;
    logic [XW-1:0]  r_clr_addr;
    logic [DCW-1:0] r_div_cnt;

    // position, with its tile coordinates
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_tc;
    logic [OW-1:0] r_ox;
    logic [YW-1:0] r_y;
    logic [YW-1:0] r_tr;
    logic [OW-1:0] r_oy;

    // divider
    logic [DW-1:0] r_dq_x;
    logic [DW-1:0] r_dq_y;
    logic [TW-1:0] r_dr_x;
    logic [TW-1:0] r_dr_y;

    // update stage and last write
    logic             r_b_valid;
    logic [XW-1:0]    r_b_tc;
    logic [YW-1:0]    r_b_tr;
    logic             r_b_first;
    logic             r_b_last;
    logic             r_b_match;
    logic             r_w_valid;
    logic [XW-1:0]    r_w_tc;
    logic [CNT_W-1:0] r_w_cnt;

    // line store
    logic [CNT_W-1:0] r_mem [0:MAX_FRAME_WIDTH-1];
    logic [CNT_W-1:0] r_rdata;

    // output register
    logic      r_out_valid;
    t_tile_out r_out;

    // effective sizes
    logic [TW-1:0]  t_eff;
    logic [TW-1:0]  t_m1;
    logic [FWW-1:0] fw_eff;
    logic [FH_W-1:0] fh_eff;

    // position logic
    logic [XW-1:0]   a_x, a_tc, c_x, c_tc, n_x, n_tc;
    logic [OW-1:0]   a_ox, a_oy, c_ox, c_oy, n_ox, n_oy;
    logic [YW-1:0]   a_y, a_tr, c_y, c_tr, n_y, n_tr;
    logic [FH_W-1:0] row_pre, row_post;
    logic [FWW-1:0]  x_inc;
    logic            c_first, c_last;

    // divider step
    logic [TW:0]   trial_x, trial_y, rem_x, rem_y;
    logic          qb_x, qb_y;
    logic [DW-1:0] dq_x_nxt, dq_y_nxt;

    // pipeline control and update
    logic             en, acc, tsize_wr;
    logic [CNT_W-1:0] base_cnt, b_cnt;
    logic             mem_we;
    logic [XW-1:0]    mem_wa;
    logic [CNT_W-1:0] mem_wd;

    // clamp configured sizes into range
    always_comb begin
        if (r_tile_size == '0) begin
            t_eff = TW'(1);
        end else if (TCW'(r_tile_size) > TCW'(MAX_TILE_SIZE)) begin
            t_eff = TW'(MAX_TILE_SIZE);
        end else begin
            t_eff = TW'(r_tile_size);
        end
        t_m1 = t_eff - TW'(1);

        if (r_frame_width == '0) begin
            fw_eff = FWW'(1);
        end else if (FCW'(r_frame_width) > FCW'(MAX_FRAME_WIDTH)) begin
            fw_eff = FWW'(MAX_FRAME_WIDTH);
        end else begin
            fw_eff = FWW'(r_frame_width);
        end

        if (r_frame_height == '0) begin
            fh_eff = FH_W'(1);
        end else if (r_frame_height > HEIGHT_LIMIT) begin
            fh_eff = HEIGHT_LIMIT;
        end else begin
            fh_eff = r_frame_height;
        end
    end

    // position of the pixel at the input and of the one after it
    always_comb begin
        // frame start
        a_x  = i_in.frame_start ? '0 : r_x;
        a_tc = i_in.frame_start ? '0 : r_tc;
        a_ox = i_in.frame_start ? '0 : r_ox;
        a_y  = i_in.frame_start ? '0 : r_y;
        a_tr = i_in.frame_start ? '0 : r_tr;
        a_oy = i_in.frame_start ? '0 : r_oy;

        // bring the position back inside a frame that has shrunk
        c_x     = a_x;
        c_tc    = a_tc;
        c_ox    = a_ox;
        c_tr    = a_tr;
        c_oy    = a_oy;
        row_pre = FH_W'(a_y);
        if (FWW'(a_x) >= fw_eff) begin
            c_x     = '0;
            c_tc    = '0;
            c_ox    = '0;
            row_pre = FH_W'(a_y) + FH_W'(1);
            if (TW'(a_oy) == t_m1) begin
                c_oy = '0;
                c_tr = a_tr + YW'(1);
            end else begin
                c_oy = a_oy + OW'(1);
            end
        end
        if (row_pre >= fh_eff) begin
            row_pre = '0;
            c_tr    = '0;
            c_oy    = '0;
        end
        c_y = row_pre[YW-1:0];

        c_first = (c_ox == '0) && (c_oy == '0);
        c_last  = (TW'(c_ox) == t_m1) && (TW'(c_oy) == t_m1);

        // step to the next pixel
        x_inc    = FWW'(c_x) + FWW'(1);
        n_y      = c_y;
        n_tr     = c_tr;
        n_oy     = c_oy;
        row_post = FH_W'(c_y);
        if (x_inc >= fw_eff) begin
            n_x      = '0;
            n_tc     = '0;
            n_ox     = '0;
            row_post = FH_W'(c_y) + FH_W'(1);
            if (TW'(c_oy) == t_m1) begin
                n_oy = '0;
                n_tr = c_tr + YW'(1);
            end else begin
                n_oy = c_oy + OW'(1);
            end
            n_y = row_post[YW-1:0];
            if (row_post >= fh_eff) begin
                n_y  = '0;
                n_tr = '0;
                n_oy = '0;
            end
        end else begin
            n_x = x_inc[XW-1:0];
            if (TW'(c_ox) == t_m1) begin
                n_ox = '0;
                n_tc = c_tc + XW'(1);
            end else begin
                n_ox = c_ox + OW'(1);
                n_tc = c_tc;
            end
        end
    end

    // one restoring divide step on column and row
    always_comb begin
        trial_x  = {r_dr_x, r_dq_x[DW-1]};
        trial_y  = {r_dr_y, r_dq_y[DW-1]};
        qb_x     = trial_x >= (TW+1)'(t_eff);
        qb_y     = trial_y >= (TW+1)'(t_eff);
        rem_x    = qb_x ? trial_x - (TW+1)'(t_eff) : trial_x;
        rem_y    = qb_y ? trial_y - (TW+1)'(t_eff) : trial_y;
        dq_x_nxt = {r_dq_x[DW-2:0], qb_x};
        dq_y_nxt = {r_dq_y[DW-2:0], qb_y};
    end

    // handshake: the update stage waits only when its result has nowhere to go
    assign en         = !(r_b_valid && r_b_last && r_out_valid && i_out_stall);
    assign o_in_stall = (r_state != ST_RUN) || !en;
    assign acc        = i_in_valid && !o_in_stall;
    assign tsize_wr   = i_cfg_we && (i_cfg_index == REG_TILE_SIZE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size    <= RST_TILE_SIZE;
            r_threshold    <= RST_THRESHOLD;
            r_match_color  <= RST_MATCH_COLOR;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TILE_SIZE:    r_tile_size    <= i_cfg_data[TS_W-1:0];
                REG_THRESHOLD:    r_threshold    <= i_cfg_data[CNT_W-1:0];
                REG_MATCH_COLOR:  r_match_color  <= i_cfg_data[COLOR_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // controller, position and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_div_cnt  <= '0;
            r_x        <= '0;
            r_tc       <= '0;
            r_ox       <= '0;
            r_y        <= '0;
            r_tr       <= '0;
            r_oy       <= '0;
            r_dq_x     <= '0;
            r_dq_y     <= '0;
            r_dr_x     <= '0;
            r_dr_y     <= '0;
        end else if (tsize_wr && (r_state != ST_CLEAR)) begin
            // new tile size: re-derive tile coordinates of the position
            r_state   <= ST_DIV;
            r_div_cnt <= '0;
            r_dq_x    <= DW'(r_x);
            r_dq_y    <= DW'(r_y);
            r_dr_x    <= '0;
            r_dr_y    <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + XW'(1);
                    if (r_clr_addr == XW'(MAX_FRAME_WIDTH - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_DIV: begin
                    r_dq_x    <= dq_x_nxt;
                    r_dq_y    <= dq_y_nxt;
                    r_dr_x    <= rem_x[TW-1:0];
                    r_dr_y    <= rem_y[TW-1:0];
                    r_div_cnt <= r_div_cnt + DCW'(1);
                    if (r_div_cnt == DCW'(DW - 1)) begin
                        r_tc    <= dq_x_nxt[XW-1:0];
                        r_ox    <= rem_x[OW-1:0];
                        r_tr    <= dq_y_nxt[YW-1:0];
                        r_oy    <= rem_y[OW-1:0];
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (acc) begin
                        r_x  <= n_x;
                        r_tc <= n_tc;
                        r_ox <= n_ox;
                        r_y  <= n_y;
                        r_tr <= n_tr;
                        r_oy <= n_oy;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    // update stage: load or accumulate, with the previous write forwarded
    always_comb begin
        if (r_b_first) begin
            base_cnt = '0;
        end else if (r_w_valid && (r_w_tc == r_b_tc)) begin
            base_cnt = r_w_cnt;
        end else begin
            base_cnt = r_rdata;
        end
        b_cnt = (r_b_match && (base_cnt != COUNT_MAX)) ? base_cnt + CNT_W'(1) : base_cnt;

        mem_we = (r_state == ST_CLEAR) || (en && r_b_valid);
        mem_wa = (r_state == ST_CLEAR) ? r_clr_addr : r_b_tc;
        mem_wd = (r_state == ST_CLEAR) ? '0 : b_cnt;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (en) begin
            r_rdata <= r_mem[c_tc];
        end
    end

    // pipeline valid bits and output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_w_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_b_valid <= acc;
                r_w_valid <= r_b_valid;
            end
            if (en && r_b_valid && r_b_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_tc    <= c_tc;
            r_b_tr    <= c_tr;
            r_b_first <= c_first;
            r_b_last  <= c_last;
            r_b_match <= (i_in.pixel_argb == r_match_color);
            r_w_tc    <= r_b_tc;
            r_w_cnt   <= b_cnt;
        end
        if (en && r_b_valid && r_b_last) begin
            r_out.tile_column <= TILE_COL_W'(r_b_tc);
            r_out.tile_row    <= r_b_tr;
            r_out.match_count <= b_cnt;
            r_out.detected    <= (b_cnt >= r_threshold);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/tccd_checker.sv
// ----------------------------------------------------------------------------
// Tile colour count detector - port checker
// Watches the detector ports for start-up behaviour, the tile size reload
// hold-off, result timing and output stability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tile_color_count_detector_macros.svh"

module tccd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [tccd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input tccd_pkg::t_tile_out            o_out
);

    import tccd_pkg::*;

    // line store clear: no item taken and no result right after reset
    `TCCD_ASSERT_IMP(a_start_hold, $past(!i_rst_n), o_in_stall && !o_out_valid, "item path open right after reset")

    // a tile size write taken while running holds input for the reload
    `TCCD_ASSERT_NXT(a_tsize_hold, i_cfg_we && (i_cfg_index == REG_TILE_SIZE) && !o_in_stall, o_in_stall, "input not held after tile size write")

    // a new result follows an accepted item that passed the update stage
    `TCCD_ASSERT_IMP(a_result_origin, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2), "result without a matching input item")

    // a stalled result item holds
    `TCCD_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result item changed")

endmodule

bind tile_color_count_detector tccd_checker u_tccd_checker (.*);
